FILE: design/dmwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwc_pkg
// Shared constants and types of the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwc_pkg;

  // default geometry
  localparam int SETS_DEFAULT           = 32;
  localparam int WORDS_PER_LINE_DEFAULT = 8;
  localparam int ADDR_BITS_DEFAULT      = 16;
  localparam int DATA_BITS_DEFAULT      = 8;

  // request function codes
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // request sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL
  } state_t;

endpackage

FILE: design/dmwc_backing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwc_backing
// Backing memory organized as whole cache lines, one line per row, with a
// clearing pass after reset that zeroes one row per cycle.
// ----------------------------------------------------------------------------
module dmwc_backing #(
  parameter int ROW_BITS  = 13,
  parameter int LINE_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [ROW_BITS-1:0]  rd_row,
  output logic [LINE_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ROW_BITS-1:0]  wr_row,
  input  logic [LINE_BITS-1:0] wr_data,
  output logic                 clear_busy
);

  localparam int ROWS = 1 << ROW_BITS;

  logic [LINE_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0]  clear_row;
  logic                 clearing;

  // clearing pass control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (clearing) begin
      clear_row <= clear_row + 1'b1;
      if (clear_row == {ROW_BITS{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // row storage: clear sweep has priority over line writes
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_row] <= '0;
    end else if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

  assign clear_busy = clearing;

endmodule

FILE: design/direct_mapped_writeback_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_top
// Direct-mapped, write-back, write-allocate cache in front of a byte memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with func, address and write_data.
//   A read returns one result on out_valid/out_ready (read_data, hit,
//   dirty); a write returns nothing.
//   Timing: a read hit loads its result in the LOOKUP state after accept,
//   a read miss in the FILL state after LOOKUP (the line writeback and
//   line fill each move a whole line in one backing-memory access). A new
//   request is taken the cycle after the previous one finishes, so the
//   cache takes no new request before it is done with the last one; the
//   tag/data memories and the backing memory have registered reads.
//   Reset: all lines become invalid and the backing memory is zeroed by a
//   clearing pass over 2^ADDR_BITS / WORDS_PER_LINE rows (8192 with the
//   defaults); in_ready stays low during that pass.
//   Stall: the result sits in an output register; while it waits, the next
//   request is still accepted and looked up, and a read completes only
//   once the output register is free.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_top #(
  parameter int SETS           = dmwc_pkg::SETS_DEFAULT,
  parameter int WORDS_PER_LINE = dmwc_pkg::WORDS_PER_LINE_DEFAULT,
  parameter int ADDR_BITS      = dmwc_pkg::ADDR_BITS_DEFAULT,
  parameter int DATA_BITS      = dmwc_pkg::DATA_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [DATA_BITS-1:0] write_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_BITS-1:0] read_data,
  output logic                 hit,
  output logic                 dirty
);

  import dmwc_pkg::*;

  localparam int OFF_BITS  = $clog2(WORDS_PER_LINE);
  localparam int SET_BITS  = $clog2(SETS);
  localparam int TAG_BITS  = ADDR_BITS - SET_BITS - OFF_BITS;
  localparam int ROW_BITS  = ADDR_BITS - OFF_BITS;
  localparam int LINE_BITS = WORDS_PER_LINE * DATA_BITS;

  typedef logic [WORDS_PER_LINE-1:0][DATA_BITS-1:0] line_t;

  state_t state, state_next;

  // cache storage
  line_t               data_mem  [SETS];
  logic [TAG_BITS-1:0] tag_mem   [SETS];
  logic                dirty_mem [SETS];
  logic [SETS-1:0]     line_valid;

  // registered read data of the cache memories
  line_t               data_rd;
  logic [TAG_BITS-1:0] tag_rd;
  logic                dirty_rd;

  // latched request
  logic                req_write;
  logic [TAG_BITS-1:0] req_tag;
  logic [SET_BITS-1:0] req_set;
  logic [OFF_BITS-1:0] req_off;
  logic [DATA_BITS-1:0] req_wdata;
  logic                miss_dirty;
  logic                miss_dirty_next;

  // backing memory interface
  logic                back_rd_en;
  logic [ROW_BITS-1:0] back_rd_row;
  logic [LINE_BITS-1:0] back_rd_data;
  logic                back_wr_en;
  logic [ROW_BITS-1:0] back_wr_row;
  logic                clear_busy;

  // cache write port and result load
  logic                line_wr_en;
  line_t               line_wr_data;
  logic                line_wr_dirty;
  logic                out_load;
  logic [DATA_BITS-1:0] out_data_next;
  logic                out_hit_next;
  logic                out_dirty_next;

  logic                in_fire;
  logic [SET_BITS-1:0] in_set;
  logic                out_free;
  logic                lookup_hit;
  logic                victim_dirty;
  line_t               fill_line;
  line_t               merged_hit;
  line_t               merged_fill;

  assign in_ready = (state == ST_IDLE) && !clear_busy;
  assign in_fire  = in_valid && in_ready;
  assign in_set   = address[OFF_BITS +: SET_BITS];
  assign out_free = !out_valid || out_ready;

  assign lookup_hit   = line_valid[req_set] && (tag_rd == req_tag);
  assign victim_dirty = line_valid[req_set] && dirty_rd;
  assign fill_line    = line_t'(back_rd_data);

  // byte merge for writes, on a hit line and on a filled line
  always_comb begin
    merged_hit           = data_rd;
    merged_hit[req_off]  = req_wdata;
    merged_fill          = fill_line;
    merged_fill[req_off] = req_wdata;
  end

  // request latch
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_write <= (func == FUNC_WRITE);
      req_tag   <= address[ADDR_BITS-1 -: TAG_BITS];
      req_set   <= in_set;
      req_off   <= address[OFF_BITS-1:0];
      req_wdata <= write_data;
    end
    miss_dirty <= miss_dirty_next;
  end

  // cache memories: read on accept, write on completion
  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_rd  <= data_mem[in_set];
      tag_rd   <= tag_mem[in_set];
      dirty_rd <= dirty_mem[in_set];
    end
    if (line_wr_en) begin
      data_mem[req_set]  <= line_wr_data;
      tag_mem[req_set]   <= req_tag;
      dirty_mem[req_set] <= line_wr_dirty;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (line_wr_en) begin
      line_valid[req_set] <= 1'b1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next      = state;
    miss_dirty_next = miss_dirty;
    back_rd_en      = 1'b0;
    back_rd_row     = {req_tag, req_set};
    back_wr_en      = 1'b0;
    back_wr_row     = {tag_rd, req_set};
    line_wr_en      = 1'b0;
    line_wr_data    = merged_hit;
    line_wr_dirty   = 1'b1;
    out_load        = 1'b0;
    out_data_next   = data_rd[req_off];
    out_hit_next    = 1'b1;
    out_dirty_next  = dirty_rd;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lookup_hit) begin
          if (req_write) begin
            line_wr_en = 1'b1;
            state_next = ST_IDLE;
          end else if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          // write back a dirty victim and fetch the new line
          back_wr_en      = victim_dirty;
          back_rd_en      = 1'b1;
          miss_dirty_next = victim_dirty;
          state_next      = ST_FILL;
        end
      end
      ST_FILL: begin
        out_data_next  = fill_line[req_off];
        out_hit_next   = 1'b0;
        out_dirty_next = miss_dirty;
        line_wr_dirty  = req_write;
        line_wr_data   = req_write ? merged_fill : fill_line;
        if (req_write || out_free) begin
          line_wr_en = 1'b1;
          out_load   = !req_write;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data <= out_data_next;
      hit       <= out_hit_next;
      dirty     <= out_dirty_next;
    end
  end

  dmwc_backing #(
    .ROW_BITS  (ROW_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_backing (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (back_rd_en),
    .rd_row     (back_rd_row),
    .rd_data    (back_rd_data),
    .wr_en      (back_wr_en),
    .wr_row     (back_wr_row),
    .wr_data    (LINE_BITS'(data_rd)),
    .clear_busy (clear_busy)
  );

endmodule
